>>> rtl/function_profile_table_defines.svh
// assertion helpers shared by the profile table rtl
`ifndef FUNCTION_PROFILE_TABLE_DEFINES_SVH
`define FUNCTION_PROFILE_TABLE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define FPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fpt_pkg.sv
`default_nettype none

package fpt_pkg;

    localparam int BUCKETS = 4096;
    localparam int WAYS    = 16;
    localparam int ENTRIES = BUCKETS * WAYS;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W = $clog2(ENTRIES);

    localparam bit BUCKETS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_MISS    = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] address;
        logic [31:0] count;
        logic [63:0] total_time;
        logic [63:0] start_time;
        logic [31:0] depth;
    } entry_t;

    function automatic logic [ADDR_W-1:0] slot_of(logic [BKT_W-1:0] bkt,
                                                  logic [WAY_W-1:0] way);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(bkt) * ADDR_W'(WAYS));
        return base + ADDR_W'(way);
    endfunction

    function automatic logic [3:0] way_low4(logic [WAY_W-1:0] way);
        logic [WAY_W+3:0] wide;
        wide = {4'b0000, way};
        return wide[3:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/fpt_ram.sv
`default_nettype none

module fpt_ram (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [fpt_pkg::ADDR_W-1:0]  wr_addr,
    input  wire fpt_pkg::entry_t             wr_data,
    input  wire logic [fpt_pkg::ADDR_W-1:0]  rd_addr,
    output fpt_pkg::entry_t                  rd_data
);

    fpt_pkg::entry_t mem [fpt_pkg::ENTRIES];
    fpt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/fpt_bucket_mod.sv
`default_nettype none

// address modulo bucket count, one hex digit per cycle, msb first
module fpt_bucket_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [63:0]                addr,
    output logic                            done,
    output logic [fpt_pkg::BKT_W-1:0]       rem
);

    localparam int V_W = fpt_pkg::BKT_W + 4;

    logic                       run_reg;
    logic                       done_reg;
    logic [3:0]                 cnt_reg;
    logic [63:0]                addr_reg;
    logic [fpt_pkg::BKT_W-1:0]  rem_reg;
    logic [fpt_pkg::BKT_W-1:0]  rem_next;
    logic [3:0]                 digit;
    logic [V_W-1:0]             v;
    logic [V_W-1:0]             sub;

    always_comb
    begin
        digit = addr_reg[{cnt_reg, 2'b00} +: 4];
        v     = {rem_reg, digit};
        sub   = '0;
        // largest multiple of the bucket count not above v
        for (int k = 1; k < 16; k++)
        begin
            if (v >= V_W'(k * fpt_pkg::BUCKETS))
            begin
                sub = V_W'(k * fpt_pkg::BUCKETS);
            end
        end
        rem_next = fpt_pkg::BKT_W'(v - sub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            addr_reg <= '0;
            rem_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                cnt_reg  <= 4'hf;
                addr_reg <= addr;
                rem_reg  <= '0;
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/fpt_entry_unit.sv
`default_nettype none

// way compare and entry update arithmetic
module fpt_entry_unit (
    input  wire logic             is_exit,
    input  wire logic [63:0]      fn_address,
    input  wire logic [63:0]      now_us,
    input  wire fpt_pkg::entry_t  probe,
    input  wire fpt_pkg::entry_t  cur,
    input  wire logic [63:0]      elapsed_in,
    output logic                  hit,
    output logic [63:0]           elapsed,
    output fpt_pkg::entry_t       upd
);

    logic match;
    logic empty;

    always_comb
    begin
        match = (probe.address == fn_address);
        empty = (probe.address == 64'd0);
        // enter also stops on the first empty way
        hit   = match || (!is_exit && empty);

        elapsed = now_us - cur.start_time;

        upd = cur;
        if (is_exit)
        begin
            if (cur.depth == 32'd1)
            begin
                upd.total_time = cur.total_time + elapsed_in;
                upd.start_time = 64'd0;
            end
            if (cur.depth != 32'd0)
            begin
                upd.depth = cur.depth - 32'd1;
            end
        end
        else
        begin
            upd.address = fn_address;
            upd.count   = cur.count + 32'd1;
            upd.depth   = cur.depth + 32'd1;
            if (cur.depth == 32'd0)
            begin
                upd.start_time = now_us;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/function_profile_table.sv
// results: a probed event raises done from S_WRITE, after S_PROBE has read its ways and S_CALC;
//   an exit miss or full bucket raises it from S_PROBE after the last way, an ignored event in the next cycle
// handshake: busy is low in the done cycle, so the next event can be accepted as it ends;
//   ignored events can be accepted every cycle
// reset: the table is swept to zero one entry per cycle, all 65536 entries, with busy high;
//   enable resets to one, the halt bit to zero; results cannot be stalled
`default_nettype none

`include "function_profile_table_defines.svh"

module function_profile_table (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic         func,
    input  wire logic [63:0]  fn_address,
    input  wire logic [63:0]  now_us,
    input  wire logic         cfg_we,
    input  wire logic         cfg_wdata,
    output logic              done,
    output logic [1:0]        status,
    output logic [3:0]        way_used,
    output logic [31:0]       call_count,
    output logic [63:0]       time_total,
    output logic [31:0]       nest_depth
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_CALC,
        S_WRITE
    } state_t;

    state_t                        state_reg;
    logic                          enable_reg;
    logic                          halted_reg;
    logic                          is_exit_reg;
    logic [63:0]                   addr_reg;
    logic [63:0]                   now_reg;
    logic [fpt_pkg::BKT_W-1:0]     bucket_reg;
    logic [fpt_pkg::WAY_W-1:0]     chk_reg;
    logic [fpt_pkg::ADDR_W-1:0]    clr_reg;
    fpt_pkg::entry_t               entry_reg;
    logic [63:0]                   elapsed_reg;

    logic                          done_reg;
    fpt_pkg::status_t              status_reg;
    logic [3:0]                    way_reg;
    logic [31:0]                   count_reg;
    logic [63:0]                   total_reg;
    logic [31:0]                   depth_reg;

    logic                          accept;
    logic                          chk_last;
    logic [fpt_pkg::WAY_W-1:0]     way_after;
    logic [fpt_pkg::BKT_W-1:0]     bucket_in;
    logic                          mod_done;
    logic [fpt_pkg::BKT_W-1:0]     mod_rem;

    logic                          ram_we;
    logic [fpt_pkg::ADDR_W-1:0]    ram_waddr;
    fpt_pkg::entry_t               ram_wdata;
    logic [fpt_pkg::ADDR_W-1:0]    ram_raddr;
    fpt_pkg::entry_t               ram_rdata;

    logic                          hit;
    logic [63:0]                   elapsed;
    fpt_pkg::entry_t               upd;

    assign accept    = start && (state_reg == S_IDLE);
    assign chk_last  = (chk_reg == fpt_pkg::WAY_W'(fpt_pkg::WAYS - 1));
    assign way_after = chk_last ? '0 : chk_reg + 1'b1;
    assign bucket_in = fn_address[fpt_pkg::BKT_W-1:0];

    fpt_bucket_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && !fpt_pkg::BUCKETS_POW2),
        .addr  (fn_address),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    fpt_ram u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    fpt_entry_unit u_unit (
        .is_exit    (is_exit_reg),
        .fn_address (addr_reg),
        .now_us     (now_reg),
        .probe      (ram_rdata),
        .cur        (entry_reg),
        .elapsed_in (elapsed_reg),
        .hit        (hit),
        .elapsed    (elapsed),
        .upd        (upd)
    );

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = fpt_pkg::slot_of(bucket_reg, chk_reg);
        ram_wdata = upd;
        ram_raddr = fpt_pkg::slot_of(bucket_reg, way_after);
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            S_IDLE:
            begin
                ram_raddr = fpt_pkg::slot_of(bucket_in, '0);
            end
            S_MOD:
            begin
                ram_raddr = fpt_pkg::slot_of(mod_rem, '0);
            end
            S_WRITE:
            begin
                ram_we = 1'b1;
            end
            S_PROBE, S_CALC:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            enable_reg  <= 1'b1;
            halted_reg  <= 1'b0;
            is_exit_reg <= 1'b0;
            addr_reg    <= '0;
            now_reg     <= '0;
            bucket_reg  <= '0;
            chk_reg     <= '0;
            clr_reg     <= '0;
            entry_reg   <= '0;
            elapsed_reg <= '0;
            done_reg    <= 1'b0;
            status_reg  <= fpt_pkg::ST_UPDATED;
            way_reg     <= '0;
            count_reg   <= '0;
            total_reg   <= '0;
            depth_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == fpt_pkg::ADDR_W'(fpt_pkg::ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        is_exit_reg <= func;
                        addr_reg    <= fn_address;
                        now_reg     <= now_us;
                        bucket_reg  <= bucket_in;
                        chk_reg     <= '0;
                        if (!enable_reg || halted_reg)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= fpt_pkg::ST_IGNORED;
                            way_reg    <= '0;
                            count_reg  <= '0;
                            total_reg  <= '0;
                            depth_reg  <= '0;
                        end
                        else if (fpt_pkg::BUCKETS_POW2)
                        begin
                            state_reg <= S_PROBE;
                        end
                        else
                        begin
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    if (mod_done)
                    begin
                        bucket_reg <= mod_rem;
                        state_reg  <= S_PROBE;
                    end
                end
                S_PROBE:
                begin
                    // ram data belongs to chk_reg, next way is already being read
                    if (hit)
                    begin
                        entry_reg <= ram_rdata;
                        state_reg <= S_CALC;
                    end
                    else if (chk_last)
                    begin
                        done_reg  <= 1'b1;
                        way_reg   <= '0;
                        count_reg <= '0;
                        total_reg <= '0;
                        depth_reg <= '0;
                        state_reg <= S_IDLE;
                        if (is_exit_reg)
                        begin
                            status_reg <= fpt_pkg::ST_MISS;
                        end
                        else
                        begin
                            status_reg <= fpt_pkg::ST_FULL;
                            halted_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        chk_reg <= way_after;
                    end
                end
                S_CALC:
                begin
                    elapsed_reg <= elapsed;
                    state_reg   <= S_WRITE;
                end
                S_WRITE:
                begin
                    done_reg   <= 1'b1;
                    status_reg <= fpt_pkg::ST_UPDATED;
                    way_reg    <= fpt_pkg::way_low4(chk_reg);
                    count_reg  <= upd.count;
                    total_reg  <= upd.total_time;
                    depth_reg  <= upd.depth;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign way_used   = way_reg;
    assign call_count = count_reg;
    assign time_total = total_reg;
    assign nest_depth = depth_reg;

    `FPT_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result beat while not idle")
    `FPT_ASSERT_NEXT(a_ignored, accept && (!enable_reg || halted_reg), done_reg && status_reg == fpt_pkg::ST_IGNORED, "ignored event not answered next cycle")
    `FPT_ASSERT_NOW(a_halt_full, $rose(halted_reg), done_reg && status_reg == fpt_pkg::ST_FULL, "halt set without bucket full beat")
    `FPT_ASSERT_NOW(a_clear_quiet, state_reg == S_CLEAR, !done_reg && ram_we, "result or missing write during clear sweep")

endmodule

`default_nettype wire

>>> test/function_profile_table_tb.sv
`default_nettype none

module function_profile_table_tb;

    localparam logic FUNC_ENTER = 1'b0;
    localparam logic FUNC_EXIT  = 1'b1;
    localparam int   CYCLE_LIMIT = 400_000;
    localparam int   HOT_FUNCS   = 20;
    localparam int   MAX_NEST    = 12;

    typedef struct packed {
        fpt_pkg::status_t status;
        logic [3:0]       way;
        logic [31:0]      count;
        logic [63:0]      total;
        logic [31:0]      depth;
    } profile_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [63:0] fn_address;
    logic [63:0] now_us;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  way_used;
    logic [31:0] call_count;
    logic [63:0] time_total;
    logic [31:0] nest_depth;

    // shadow copy of the profile table, only touched slots are stored
    fpt_pkg::entry_t prof_table[int];
    logic            prof_enable;
    logic            prof_halted;
    profile_result_t expected_results[$];

    logic [63:0] hot_funcs[HOT_FUNCS];
    logic [63:0] call_stack[$];
    logic [63:0] sim_now;
    int          sender_idle_pct;
    int          events_sent;
    int          mismatch_count;
    int          cycle_count;
    int          seen_updated;
    int          seen_ignored;
    int          seen_miss;
    int          seen_full;

    function_profile_table u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .fn_address (fn_address),
        .now_us     (now_us),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .status     (status),
        .way_used   (way_used),
        .call_count (call_count),
        .time_total (time_total),
        .nest_depth (nest_depth)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic fpt_pkg::entry_t read_entry(int slot);
        if (prof_table.exists(slot))
            return prof_table[slot];
        return '0;
    endfunction

    function automatic int bucket_base(logic [63:0] addr);
        return int'(addr % 64'(fpt_pkg::BUCKETS)) * fpt_pkg::WAYS;
    endfunction

    // true when an enter of addr would find its entry or a free way
    function automatic bit bucket_has_room(logic [63:0] addr);
        fpt_pkg::entry_t e;
        int              base;
        base = bucket_base(addr);
        for (int w = 0; w < fpt_pkg::WAYS; w++)
        begin
            e = read_entry(base + w);
            if (e.address == addr || e.address == '0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic profile_result_t profile_event(logic is_exit, logic [63:0] addr,
                                                      logic [63:0] now);
        profile_result_t r;
        fpt_pkg::entry_t e;
        int              base;
        int              hit;
        r = '0;
        if (!prof_enable || prof_halted)
        begin
            r.status = fpt_pkg::ST_IGNORED;
            return r;
        end
        base = bucket_base(addr);
        hit  = -1;
        // enter also stops on an empty way, exit only on a matching address
        for (int w = 0; w < fpt_pkg::WAYS && hit < 0; w++)
        begin
            e = read_entry(base + w);
            if (e.address == addr || (!is_exit && e.address == '0))
                hit = w;
        end
        if (hit < 0)
        begin
            if (is_exit)
                r.status = fpt_pkg::ST_MISS;
            else
            begin
                prof_halted = 1'b1;
                r.status    = fpt_pkg::ST_FULL;
            end
            return r;
        end
        e = read_entry(base + hit);
        if (!is_exit)
        begin
            e.address = addr;
            e.count   = e.count + 32'd1;
            e.depth   = e.depth + 32'd1;
            if (e.depth == 32'd1)
                e.start_time = now;
        end
        else
        begin
            if (e.depth == 32'd1)
            begin
                e.total_time = e.total_time + (now - e.start_time);
                e.start_time = '0;
            end
            if (e.depth != 32'd0)
                e.depth = e.depth - 32'd1;
        end
        prof_table[base + hit] = e;
        r.status = fpt_pkg::ST_UPDATED;
        r.way    = hit[3:0];
        r.count  = e.count;
        r.total  = e.total_time;
        r.depth  = e.depth;
        return r;
    endfunction

    task automatic post_event(input logic is_exit, input logic [63:0] addr,
                              input logic [63:0] now);
        @(negedge clk);
        start      <= 1'b1;
        func       <= is_exit;
        fn_address <= addr;
        now_us     <= now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(profile_event(is_exit, addr, now));
        events_sent++;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_enable(input logic value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        prof_enable = value;
    endtask

    // nested enters of one function, unwind, then one exit too many
    task automatic test_nesting();
        logic [63:0] fa;
        fa = 64'h0000_7f12_3456_7005;
        post_event(FUNC_ENTER, fa, 64'd100);
        post_event(FUNC_ENTER, fa, 64'd150);
        post_event(FUNC_EXIT,  fa, 64'd400);
        post_event(FUNC_EXIT,  fa, 64'd1000);
        post_event(FUNC_EXIT,  fa, 64'd2000);
    endtask

    // address zero updates a way without claiming it, a later address inherits the stats
    task automatic test_zero_address();
        post_event(FUNC_ENTER, 64'h0, 64'd10);
        post_event(FUNC_ENTER, 64'h0, 64'd20);
        post_event(FUNC_EXIT,  64'h0, 64'd35);
        post_event(FUNC_ENTER, 64'h0000_0000_0000_1000, 64'd50);
        post_event(FUNC_EXIT,  64'h0, 64'd60);
    endtask

    task automatic test_field_extremes();
        post_event(FUNC_ENTER, '1, '1);
        post_event(FUNC_EXIT,  '1, 64'd0);
        post_event(FUNC_ENTER, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
        post_event(FUNC_EXIT,  64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        post_event(FUNC_EXIT,  64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    task automatic test_enable_toggle();
        write_enable(1'b0);
        post_event(FUNC_ENTER, 64'h0000_1234_0000_0abc, 64'd5000);
        post_event(FUNC_EXIT,  64'h0000_7f12_3456_7005, 64'd5100);
        write_enable(1'b1);
        post_event(FUNC_ENTER, 64'h0000_1234_0000_0abc, 64'd5200);
    endtask

    task automatic run_random_phase(input int n_events);
        logic [63:0] addr;
        int          roll;
        int          sel;
        for (int i = 0; i < n_events; i++)
        begin
            roll = $urandom_range(99);
            // mostly monotonic time, now and then a jump anywhere to exercise wrap
            if ($urandom_range(99) < 4)
                sim_now = {$urandom, $urandom};
            else
                sim_now = sim_now + 64'($urandom_range(700, 1));
            if (roll < 45 && call_stack.size() < MAX_NEST)
            begin
                sel = $urandom_range(99);
                if (sel < 85)
                    addr = hot_funcs[$urandom_range(HOT_FUNCS - 1)];
                else if (sel < 97)
                    addr = {$urandom, $urandom};
                else
                    addr = '0;
                // the halt is sticky, so a full bucket is kept for the last test
                if (bucket_has_room(addr))
                begin
                    call_stack.push_back(addr);
                    post_event(FUNC_ENTER, addr, sim_now);
                end
                else
                    post_event(FUNC_EXIT, addr, sim_now);
            end
            else if (roll < 88 && call_stack.size() != 0)
                post_event(FUNC_EXIT, call_stack.pop_back(), sim_now);
            else
            begin
                sel = $urandom_range(99);
                if (sel < 50)
                    addr = hot_funcs[$urandom_range(HOT_FUNCS - 1)];
                else if (sel < 90)
                    addr = {$urandom, $urandom};
                else
                    addr = '0;
                post_event(FUNC_EXIT, addr, sim_now);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [63:0] addr;
        // hot functions crowd four buckets so ways past zero get used
        for (int i = 0; i < HOT_FUNCS; i++)
        begin
            addr = {$urandom, $urandom};
            hot_funcs[i] = addr - (addr % 64'(fpt_pkg::BUCKETS)) + 64'(960 + i % 4);
        end
        sim_now = 64'd10_000;
        sender_idle_pct = 19;
        run_random_phase(170);
        write_enable(1'b0);
        run_random_phase(6);
        write_enable(1'b1);
        sender_idle_pct = 51;
        run_random_phase(170);
        sender_idle_pct = 0;
        run_random_phase(170);
    endtask

    // sixteen distinct functions in one bucket, the next one halts profiling for good
    task automatic test_bucket_full();
        logic [63:0] addr;
        for (int i = 0; i < fpt_pkg::WAYS + 2 && !prof_halted; i++)
        begin
            addr = {$urandom, $urandom};
            addr = addr - (addr % 64'(fpt_pkg::BUCKETS)) + 64'h777;
            post_event(FUNC_ENTER, addr, sim_now + 64'(i));
        end
        post_event(FUNC_ENTER, hot_funcs[0], sim_now + 64'd100);
        post_event(FUNC_EXIT,  hot_funcs[0], sim_now + 64'd200);
        write_enable(1'b0);
        post_event(FUNC_ENTER, hot_funcs[1], sim_now + 64'd300);
        write_enable(1'b1);
        post_event(FUNC_EXIT,  hot_funcs[1], sim_now + 64'd400);
    endtask

    // one beat per cycle at most, the receiver cannot stall
    always @(posedge clk)
    begin
        profile_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                case (status)
                    fpt_pkg::ST_UPDATED: seen_updated++;
                    fpt_pkg::ST_IGNORED: seen_ignored++;
                    fpt_pkg::ST_MISS:    seen_miss++;
                    default:             seen_full++;
                endcase
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatch_count++;
                end
                if (way_used !== want.way)
                begin
                    $error("way_used: expected %0d, got %0d", want.way, way_used);
                    mismatch_count++;
                end
                if (call_count !== want.count)
                begin
                    $error("call_count: expected %0d, got %0d", want.count, call_count);
                    mismatch_count++;
                end
                if (time_total !== want.total)
                begin
                    $error("time_total: expected %0h, got %0h", want.total, time_total);
                    mismatch_count++;
                end
                if (nest_depth !== want.depth)
                begin
                    $error("nest_depth: expected %0d, got %0d", want.depth, nest_depth);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = 1'b0;
        fn_address  = '0;
        now_us      = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        prof_enable = 1'b1;
        prof_halted = 1'b0;
        sim_now     = '0;
        sender_idle_pct = 19;
        events_sent    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        seen_updated   = 0;
        seen_ignored   = 0;
        seen_miss      = 0;
        seen_full      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // enable comes out of reset high, write it anyway before traffic
        write_enable(1'b1);
        test_nesting();
        test_zero_address();
        test_field_extremes();
        test_enable_toggle();
        test_random_traffic();
        test_bucket_full();

        wait_idle();
        repeat (25) @(posedge clk);
        $display("sent %0d events over directed, random and bucket-full tests", events_sent);
        $display("results: %0d updated, %0d ignored, %0d exit misses, %0d bucket full",
                 seen_updated, seen_ignored, seen_miss, seen_full);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
